// ===== src/lzwd_pkg.sv =====
// Shared types, constants and codes for the LZ window decompressor.
package lzwd_pkg;

  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int LANES_DEF        = 8;
  localparam int LEN_W            = 9;
  localparam int DIST_W           = 13;
  localparam int COUNT_W          = 32;
  localparam int OUT_W            = 64;

  localparam logic [LEN_W-1:0] LONG_BASE  = 9'h012;
  localparam logic [LEN_W-1:0] SHORT_BASE = 9'h002;

  // Parser position within the compressed stream.
  typedef enum logic [1:0] {
    PH_FLAG,
    PH_ITEM,
    PH_TOK2,
    PH_TOK3
  } phase_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LIT,
    S_RD,
    S_WR,
    S_FLUSH_MID,
    S_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic put_lit;
    logic put_copy;
    logic finish;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic start_lit;
    logic start_copy;
    logic copy_end;
    logic lane_last;
    logic acc_nonempty;
    logic out_free;
  } stat_t;

endpackage

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/lzwd_ctrl.sv =====
// Controller state machine sequencing literals, copies and word flushes.
module lzwd_ctrl
  import lzwd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !st.done) begin
          if (st.start_lit) begin
            state_nxt = S_LIT;
          end else if (st.start_copy) begin
            state_nxt = S_RD;
          end
        end
      end
      S_LIT: state_nxt = S_FLUSH;
      S_RD: begin
        if (st.copy_end) begin
          state_nxt = st.acc_nonempty ? S_FLUSH : S_IDLE;
        end else begin
          state_nxt = S_WR;
        end
      end
      S_WR: state_nxt = st.lane_last ? S_FLUSH_MID : S_RD;
      S_FLUSH_MID: begin
        if (st.out_free) begin
          state_nxt = S_RD;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: cmd.take = in_valid;
      S_LIT: begin
        cmd.put_lit = 1'b1;
        cmd.finish  = 1'b1;
      end
      S_RD:        cmd.finish   = st.copy_end;
      S_WR:        cmd.put_copy = 1'b1;
      S_FLUSH_MID: cmd.flush    = st.out_free;
      S_FLUSH:     cmd.flush    = st.out_free;
      default:     cmd          = '0;
    endcase
  end

endmodule

// ===== src/lzwd_datapath.sv =====
// Datapath: parser registers, history window, byte packing and result register.
module lzwd_datapath
  import lzwd_pkg::*;
#(
  parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
  parameter int LANES_PER_RESULT = LANES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_data_byte,
  input  logic               cfg_valid,
  input  logic [COUNT_W-1:0] cfg_expanded_length,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [OUT_W-1:0]   out_bytes,
  input  cmd_t               cmd,
  output stat_t              st
);

  localparam int WPW = $clog2(WINDOW_DEPTH);
  localparam int CW  = $clog2(LANES_PER_RESULT + 1);
  localparam int LW  = (LANES_PER_RESULT > 1) ? $clog2(LANES_PER_RESULT) : 1;

  logic [WPW-1:0]     wp_r;
  logic [COUNT_W-1:0] produced_r;
  logic [COUNT_W-1:0] explen_r;
  logic [7:0]         flags_r;
  logic [3:0]         remain_r;
  phase_t             phase_r;
  logic [7:0]         thi_r, tlo_r, lit_r;
  logic [LEN_W-1:0]   len_r;
  logic [7:0]         acc_r [LANES_PER_RESULT];
  logic [CW-1:0]      cnt_r;
  logic [OUT_W-1:0]   out_r;
  logic               out_valid_r;

  logic               done;
  logic [2:0]         sel;
  logic [DIST_W-1:0]  back_dist;
  logic               fault;
  logic               put;
  logic [7:0]         put_byte;
  logic [7:0]         ram_rdata;
  logic [WPW-1:0]     raddr;
  logic [3:0]         remain_dec;
  logic               out_free;
  logic [OUT_W-1:0]   acc_word;

  assign done       = (produced_r >= explen_r);
  assign sel        = remain_r[2:0] - 3'd1;
  assign back_dist  = {1'b0, thi_r[3:0], tlo_r} + DIST_W'(1);
  assign fault      = ({{(COUNT_W-DIST_W){1'b0}}, back_dist} > produced_r);
  assign put        = cmd.put_lit | cmd.put_copy;
  assign put_byte   = cmd.put_lit ? lit_r : (fault ? 8'h00 : ram_rdata);
  assign raddr      = wp_r - back_dist[WPW-1:0];
  assign remain_dec = (remain_r != 4'd0) ? remain_r - 4'd1 : 4'd0;
  assign out_free   = !out_valid_r || !out_stall;

  // Status to the controller.
  always_comb begin
    st.done         = done;
    st.start_lit    = (phase_r == PH_ITEM) && flags_r[sel];
    st.start_copy   = ((phase_r == PH_TOK2) && (thi_r[7:4] != 4'd0)) ||
                      (phase_r == PH_TOK3);
    st.copy_end     = (len_r == '0) || done;
    st.lane_last    = (cnt_r == CW'(LANES_PER_RESULT - 1));
    st.acc_nonempty = (cnt_r != '0);
    st.out_free     = out_free;
  end

  // History window.
  lzwd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk     (clk),
    .we      (put),
    .waddr   (wp_r),
    .wdata   (put_byte),
    .raddr   (raddr),
    .rdata_r (ram_rdata)
  );

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      explen_r <= '0;
    end else if (cfg_valid) begin
      explen_r <= cfg_expanded_length;
    end
  end

  // Parser state and copy length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r  <= '0;
      remain_r <= '0;
      phase_r  <= PH_FLAG;
      thi_r    <= '0;
      tlo_r    <= '0;
      len_r    <= '0;
    end else begin
      if (cmd.take && !done) begin
        unique case (phase_r)
          PH_FLAG: begin
            flags_r  <= in_data_byte;
            remain_r <= 4'd8;
            phase_r  <= PH_ITEM;
          end
          PH_ITEM: begin
            if (!flags_r[sel]) begin
              thi_r   <= in_data_byte;
              phase_r <= PH_TOK2;
            end
          end
          PH_TOK2: begin
            tlo_r <= in_data_byte;
            if (thi_r[7:4] != 4'd0) begin
              len_r <= {5'd0, thi_r[7:4]} + SHORT_BASE;
            end else begin
              phase_r <= PH_TOK3;
            end
          end
          PH_TOK3: len_r <= {1'b0, in_data_byte} + LONG_BASE;
          default: phase_r <= PH_FLAG;
        endcase
      end
      if (cmd.put_copy) begin
        len_r <= len_r - LEN_W'(1);
      end
      if (cmd.finish) begin
        remain_r <= remain_dec;
        phase_r  <= (remain_dec == 4'd0) ? PH_FLAG : PH_ITEM;
      end
    end
  end

  // Literal byte holding register.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lit_r <= in_data_byte;
    end
  end

  // Window pointer and produced count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      produced_r <= '0;
    end else if (put) begin
      wp_r       <= wp_r + WPW'(1);
      produced_r <= produced_r + COUNT_W'(1);
    end
  end

  // Packing word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < LANES_PER_RESULT; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.flush) begin
      cnt_r <= '0;
      for (int i = 0; i < LANES_PER_RESULT; i++) begin
        acc_r[i] <= '0;
      end
    end else if (put) begin
      acc_r[cnt_r[LW-1:0]] <= put_byte;
      cnt_r                <= cnt_r + CW'(1);
    end
  end

  // Lanes gathered into one word, unused high lanes zero.
  always_comb begin
    acc_word = '0;
    for (int i = 0; i < LANES_PER_RESULT; i++) begin
      acc_word[8*i +: 8] = acc_r[i];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      out_r <= acc_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bytes = out_r;

  // Checks on counting and packing.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LANES_PER_RESULT))
    else $error("packing count beyond lane count");
  a_wp_track: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == produced_r[WPW-1:0])
    else $error("window pointer out of step with produced count");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    put |=> produced_r == $past(produced_r) + COUNT_W'(1))
    else $error("produced count did not advance by one");
  a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> out_free)
    else $error("flush into an occupied result register");

endmodule

// ===== src/lz_window_decompressor.sv =====
// Top level of the LZ window decompressor: controller plus datapath.
// Takes the compressed stream body (after the 16-byte header) one byte per
// input word and returns decoded bytes packed up to LANES_PER_RESULT per
// result word, first byte in bits 7..0, unused high lanes zero; each item's
// bytes start a fresh word. A literal is accepted, written to the window and
// then handed off as a word. A back-reference alternates a read state and a
// write state for each copied byte, as the window RAM's read is registered
// and must see the previous byte before the next read so overlapping copies
// stay exact, and hands off each full result word in a flush state. Input
// is stalled while an item is expanding. Once expanded_length bytes are out,
// further input is dropped. A distance reaching before the first byte yields
// zero bytes. Write expanded_length only while the block is idle.
module lz_window_decompressor
  import lzwd_pkg::*;
#(
  parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
  parameter int LANES_PER_RESULT = LANES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   out_bytes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_expanded_length
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  // Sequencer.
  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath.
  lzwd_datapath #(
    .WINDOW_DEPTH     (WINDOW_DEPTH),
    .LANES_PER_RESULT (LANES_PER_RESULT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data_byte        (in_data_byte),
    .cfg_valid           (cfg_valid),
    .cfg_expanded_length (cfg_expanded_length),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_bytes           (out_bytes),
    .cmd                 (cmd),
    .st                  (st)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the LZ window decompressor: directed and random streams.
`timescale 1ns / 1ps

module tb;
  import lzwd_pkg::*;

  localparam int LIMIT_CYCLES = 5000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_data_byte;
  logic               out_valid;
  logic               out_stall;
  logic [OUT_W-1:0]   out_bytes;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_expanded_length;

  lz_window_decompressor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_bytes(out_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_expanded_length(cfg_expanded_length)
  );

  // Predictor state for the decoder.
  logic [7:0]  hist_mem [WINDOW_DEPTH_DEF];
  logic [11:0] hist_ptr;
  logic [7:0]  grp_flags;
  int          grp_left;
  phase_t      parse_ph;
  logic [7:0]  tok_hi;
  logic [7:0]  tok_lo;
  logic [31:0] bytes_out;
  logic [31:0] size_limit;

  logic [63:0] expected_words [$];
  logic [63:0] pack_word;
  int          pack_lane;
  int          error_count;
  int          cycle_count;
  bit          hold_rx;

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    error_count++;
  endtask

  function automatic void emit_byte(input logic [7:0] b);
    pack_word[8*pack_lane +: 8] = b;
    pack_lane++;
    if (pack_lane == LANES_DEF) begin
      expected_words.push_back(pack_word);
      pack_word = '0;
      pack_lane = 0;
    end
    hist_mem[hist_ptr] = b;
    hist_ptr = hist_ptr + 12'd1;
    bytes_out = bytes_out + 32'd1;
  endfunction

  function automatic void expand_copy(input int unsigned count);
    int unsigned back_dist;
    logic [7:0]  b;
    back_dist = {tok_hi[3:0], tok_lo} + 1;
    for (int unsigned i = 0; i < count && bytes_out < size_limit; i++) begin
      b = 8'h00;
      if (back_dist <= bytes_out) b = hist_mem[hist_ptr - back_dist[11:0]];
      emit_byte(b);
    end
  endfunction

  function automatic void item_done();
    if (grp_left > 0) grp_left--;
    parse_ph = (grp_left == 0) ? PH_FLAG : PH_ITEM;
  endfunction

  // Work out the result words that one stream byte causes.
  function automatic void predict_byte(input logic [7:0] b);
    pack_word = '0;
    pack_lane = 0;
    if (bytes_out >= size_limit) return;
    case (parse_ph)
      PH_FLAG: begin
        grp_flags = b;
        grp_left = 8;
        parse_ph = PH_ITEM;
      end
      PH_ITEM: begin
        if (grp_flags[grp_left-1]) begin
          emit_byte(b);
          item_done();
        end else begin
          tok_hi = b;
          parse_ph = PH_TOK2;
        end
      end
      PH_TOK2: begin
        tok_lo = b;
        if (tok_hi[7:4] != 0) begin
          expand_copy(tok_hi[7:4] + SHORT_BASE);
          item_done();
        end else begin
          parse_ph = PH_TOK3;
        end
      end
      default: begin
        expand_copy(b + LONG_BASE);
        item_done();
      end
    endcase
    if (pack_lane != 0) expected_words.push_back(pack_word);
  endfunction

  function automatic void reset_predictor();
    hist_ptr = '0;
    grp_flags = '0;
    grp_left = 0;
    parse_ph = PH_FLAG;
    tok_hi = '0;
    tok_lo = '0;
    bytes_out = '0;
    size_limit = '0;
  endfunction

  // Short gap most of the time, a long one now and then.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Valid stays high across back-to-back words; it drops only for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    // A token byte or a dropped byte causes no word; let the block settle.
    repeat (700) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] len);
    cfg_valid <= 1'b1;
    cfg_expanded_length <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_limit = len;
  endtask

  // Random stream of well-formed groups with random content, with stray single bytes mixed in.
  task automatic send_groups(input int n_bytes, input bit far_refs);
    int sent;
    logic [7:0] flags;
    logic [7:0] hi;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(19) == 0) begin
        send_byte(8'($urandom));
        sent++;
        continue;
      end
      flags = 8'($urandom);
      send_byte(flags);
      sent++;
      for (int k = 7; k >= 0; k--) begin
        if (flags[k]) begin
          send_byte(8'($urandom));
          sent++;
        end else begin
          hi = 8'($urandom);
          if ($urandom_range(5) == 0) hi[7:4] = 4'h0;
          if (!far_refs) hi[3:0] = 4'h0;
          send_byte(hi);
          send_byte(far_refs ? 8'($urandom) : 8'($urandom_range(15)));
          sent += 2;
          if (hi[7:4] == 0) begin
            send_byte($urandom_range(3) == 0 ? 8'hFF : 8'($urandom_range(20)));
            sent++;
          end
        end
      end
    end
  endtask

  typedef struct {
    logic [7:0]  data;
    bit          has_exp;
    logic [63:0] exp_word;
  } stim_row_t;

  // Directed stream: literal group, short and long copies, far distance.
  stim_row_t dir_rows [] = '{
    '{8'hFF, 0, 64'h0},
    '{8'h00, 1, 64'h00},
    '{8'hFF, 1, 64'hFF},
    '{8'h41, 1, 64'h41},
    '{8'h42, 1, 64'h42},
    '{8'h80, 1, 64'h80},
    '{8'h01, 1, 64'h01},
    '{8'h7F, 1, 64'h7F},
    '{8'hFE, 1, 64'hFE},
    '{8'h5A, 0, 64'h0},
    '{8'h10, 0, 64'h0},
    '{8'h00, 0, 64'h0},
    '{8'hF0, 0, 64'h0},
    '{8'h07, 0, 64'h0},
    '{8'h00, 0, 64'h0},
    '{8'h01, 0, 64'h0},
    '{8'hFF, 0, 64'h0},
    '{8'hFF, 0, 64'h0},
    '{8'h2F, 0, 64'h0},
    '{8'hFF, 0, 64'h0},
    '{8'hFF, 0, 64'h0},
    '{8'h00, 0, 64'h0},
    '{8'h00, 0, 64'h0},
    '{8'h33, 0, 64'h0}
  };

  // Result side: random stalls plus one long hold-off.
  initial begin
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) out_stall <= 1'b1;
      else out_stall <= (pick_gap() != 0);
    end
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_bytes, 64'h0);
      end else begin
        if (out_bytes !== expected_words[0])
          report_mismatch("out_bytes", out_bytes, expected_words[0]);
        void'(expected_words.pop_front());
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int base_q;
    error_count = 0;
    cycle_count = 0;
    hold_rx = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    cfg_valid = 1'b0;
    cfg_expanded_length = '0;
    reset_predictor();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero length: every byte is dropped.
    write_length(32'd0);
    send_byte(8'hFF);
    send_byte(8'h12);
    wait_drained();

    // Directed table under the largest length.
    write_length(32'hFFFF_FFFF);
    foreach (dir_rows[i]) begin
      base_q = expected_words.size();
      send_byte(dir_rows[i].data);
      if (dir_rows[i].has_exp && expected_words.size() > base_q &&
          expected_words[$] !== dir_rows[i].exp_word)
        report_mismatch("directed table", expected_words[$], dir_rows[i].exp_word);
    end
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    hold_rx = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      send_groups(30, 1'b0);
    join
    wait_drained();

    // Sender pause until all results are in, then a far-distance stream.
    send_groups(120, 1'b1);
    wait_drained();

    // Continued stream with a small length so the cut can fall mid-copy.
    // Block is reset-free here, so the predictor keeps its state.
    write_length(bytes_out + 32'd37);
    send_groups(60, 1'b0);
    wait_drained();

    write_length(bytes_out + 32'd5000);
    send_groups(140, 1'b0);
    wait_drained();

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
